>>> rtl/core/lmes_pkg.sv
// Shared types and constants of the mirrored-border Laplacian stream block.
package lmes_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int PIX_W     = 8;
    localparam int POS_W     = 11;
    localparam int LAP_W     = 11;
    localparam int CFG_W     = 12;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int WORD_W    = 2 * PIX_W;
    localparam int ODATA_W   = ((3 * POS_W + 7) / 8) * 8;
    localparam int PAD_W     = ODATA_W - 3 * POS_W;
    localparam int FIFO_D    = 4;
    localparam int FPTR_W    = $clog2(FIFO_D);
    localparam int FCNT_W    = FPTR_W + 1;

    localparam logic [CFG_W-1:0] MAX_WIDTH_CFG = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] MAX_HEIGHT_CFG = CFG_W'(2048);

    // Configuration register indexes.
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic                    eof;
        logic signed [LAP_W-1:0] lap;
        logic [POS_W-1:0]        y;
        logic [POS_W-1:0]        x;
    } t_result;

endpackage

>>> rtl/core/lmes_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lmes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/laplacian_mirror_edge_stream.sv
// Top level of the streaming 4-neighbour Laplacian with mirrored image borders.
//
// Pixels enter in raster order, one item per clock while the result queue has
// room, and each gives the Laplacian of the pixel one row above it, tagged
// with x_pos and y_pos; the last row's results follow one pixel late and the
// bottom right result carries tlast. One RAM word per column holds the two
// previous rows, written and read ahead at the next column on every accepted
// item, so interior rows run at one item per cycle while the output accepts
// results. On the last row most items give two results (three at the end of
// the frame), and the output port's single result per cycle then sets the pace.
// The line RAM needs no clearing pass; a configuration write restarts the frame.
module laplacian_mirror_edge_stream (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Pixel input: tdata = pixel_value.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [lmes_pkg::PIX_W-1:0]         i_s_tdata,
    // Results: tdata = x_pos, y_pos, laplacian_value, zero padding.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [lmes_pkg::ODATA_W-1:0]       o_m_tdata,
    output logic                               o_m_tlast,
    // Configuration writes: index 0 image_width, index 1 image_height.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic [lmes_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int PW = lmes_pkg::PIX_W;
    localparam int XW = lmes_pkg::POS_W;

    function automatic logic [XW-1:0] last_index(input logic [lmes_pkg::CFG_W-1:0] v,
                                                 input logic [lmes_pkg::CFG_W-1:0] lim);
        logic [lmes_pkg::CFG_W-1:0] t;
        begin
            if (v == '0) begin
                t = '0;
            end else if (v > lim) begin
                t = lim - 1'b1;
            end else begin
                t = v - 1'b1;
            end
            return t[XW-1:0];
        end
    endfunction

    function automatic logic signed [lmes_pkg::LAP_W-1:0] lap4(
        input logic [PW-1:0] l, input logic [PW-1:0] r,
        input logic [PW-1:0] u, input logic [PW-1:0] d,
        input logic [PW-1:0] c);
        logic [PW+1:0] s;
        begin
            s = (PW+2)'(l) + (PW+2)'(r) + (PW+2)'(u) + (PW+2)'(d);
            return $signed({1'b0, s}) - $signed({1'b0, c, 2'b00});
        end
    endfunction

    // Frame geometry and position of the next pixel.
    logic [XW-1:0]  r_wlast, r_hlast;
    logic [XW-1:0]  r_x, r_y;
    logic [PW-1:0]  r_left, r_left2, r_last_ctr;

    // Stage 1: the accepted item with its column word.
    logic                         r_s1_valid;
    logic [PW-1:0]                r_s1_pix, r_s1_left, r_s1_left2, r_s1_lctr;
    logic [XW-1:0]                r_s1_x, r_s1_y;
    logic [lmes_pkg::WORD_W-1:0]  r_s1_word;

    // Read bypass for a one-column image, where read and write hit the same word.
    logic                         r_byp_hit;
    logic [lmes_pkg::WORD_W-1:0]  r_byp_word;

    // Result queue.
    lmes_pkg::t_result            r_fifo [lmes_pkg::FIFO_D];
    logic [lmes_pkg::FPTR_W-1:0]  r_wp, r_rp;
    logic [lmes_pkg::FCNT_W-1:0]  r_cnt;

    logic                         s_acc, m_acc, cfg_acc, s1_go, x_last, y_last;
    logic [XW-1:0]                n_x, n_y, rd_addr;
    logic [lmes_pkg::WORD_W-1:0]  ram_q, word_q, wr_word;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;
    assign s1_go       = r_s1_valid && (r_cnt <= lmes_pkg::FCNT_W'(1));
    assign o_s_tready  = !r_s1_valid || (r_cnt <= lmes_pkg::FCNT_W'(1));
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign m_acc       = o_m_tvalid && i_m_tready;

    assign x_last  = (r_x == r_wlast);
    assign y_last  = (r_y == r_hlast);
    assign rd_addr = x_last ? '0 : r_x + 1'b1;
    assign word_q  = r_byp_hit ? r_byp_word : ram_q;
    // Word layout: low half is the previous row, high half the row before it.
    assign wr_word = {word_q[PW-1:0], i_s_tdata};

    always_comb begin
        if (x_last) begin
            n_x = '0;
            n_y = y_last ? '0 : r_y + 1'b1;
        end else begin
            n_x = r_x + 1'b1;
            n_y = r_y;
        end
    end

    lmes_ram #(
        .WIDTH (lmes_pkg::WORD_W),
        .DEPTH (lmes_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s_acc),
        .i_waddr (r_x[lmes_pkg::ADDR_W-1:0]),
        .i_wdata (wr_word),
        .i_re    (s_acc),
        .i_raddr (rd_addr[lmes_pkg::ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast    <= last_index(lmes_pkg::MAX_WIDTH_CFG, lmes_pkg::MAX_WIDTH_CFG);
            r_hlast    <= last_index(lmes_pkg::MAX_HEIGHT_CFG, lmes_pkg::MAX_HEIGHT_CFG);
            r_x        <= '0;
            r_y        <= '0;
            r_left     <= '0;
            r_left2    <= '0;
            r_byp_hit  <= 1'b0;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                lmes_pkg::REG_IMAGE_WIDTH: begin
                    r_wlast <= last_index(i_cfg_data, lmes_pkg::MAX_WIDTH_CFG);
                end
                lmes_pkg::REG_IMAGE_HEIGHT: begin
                    r_hlast <= last_index(i_cfg_data, lmes_pkg::MAX_HEIGHT_CFG);
                end
                default: begin
                end
            endcase
            r_x     <= '0;
            r_y     <= '0;
            r_left  <= '0;
            r_left2 <= '0;
        end else if (s_acc) begin
            r_x       <= n_x;
            r_y       <= n_y;
            r_left    <= i_s_tdata;
            r_left2   <= r_left;
            r_byp_hit <= (rd_addr == r_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_byp_word <= wr_word;
            r_last_ctr <= word_q[PW-1:0];
            r_s1_pix   <= i_s_tdata;
            r_s1_x     <= r_x;
            r_s1_y     <= r_y;
            r_s1_word  <= word_q;
            r_s1_lctr  <= r_last_ctr;
            r_s1_left  <= r_left;
            r_s1_left2 <= r_left2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 results: the row-late one, the last-row pixel-late one, the flush.
    logic              v0, v1, v2, s1_xlast, s1_ylast, h_ge2;
    logic [PW-1:0]     ctr, c0l, c0r, c0u, c1l, c1u, c2l, c2u;
    lmes_pkg::t_result d0, d1, d2;

    always_comb begin
        s1_xlast = (r_s1_x == r_wlast);
        s1_ylast = (r_s1_y == r_hlast);
        h_ge2    = (r_hlast != '0);
        ctr      = r_s1_word[PW-1:0];

        v0  = (r_s1_y != '0);
        c0l = (r_s1_x != '0) ? r_s1_lctr : ctr;
        c0r = s1_xlast ? ctr : word_q[PW-1:0];
        c0u = (r_s1_y[XW-1:1] != '0) ? r_s1_word[2*PW-1:PW] : ctr;
        d0.x   = r_s1_x;
        d0.y   = r_s1_y - 1'b1;
        d0.lap = lap4(c0l, c0r, c0u, r_s1_pix, ctr);
        d0.eof = 1'b0;

        v1  = s1_ylast && (r_s1_x != '0);
        c1l = (r_s1_x[XW-1:1] != '0) ? r_s1_left2 : r_s1_left;
        c1u = h_ge2 ? r_s1_lctr : r_s1_left;
        d1.x   = r_s1_x - 1'b1;
        d1.y   = r_s1_y;
        d1.lap = lap4(c1l, r_s1_pix, c1u, r_s1_left, r_s1_left);
        d1.eof = 1'b0;

        v2  = s1_ylast && s1_xlast;
        c2l = (r_s1_x != '0) ? r_s1_left : r_s1_pix;
        c2u = h_ge2 ? ctr : r_s1_pix;
        d2.x   = r_s1_x;
        d2.y   = r_s1_y;
        d2.lap = lap4(c2l, r_s1_pix, c2u, r_s1_pix, r_s1_pix);
        d2.eof = 1'b1;
    end

    logic [lmes_pkg::FPTR_W-1:0] wp1, wp2;
    logic [lmes_pkg::FCNT_W-1:0] n_push;

    assign wp1    = r_wp + lmes_pkg::FPTR_W'(v0);
    assign wp2    = wp1 + lmes_pkg::FPTR_W'(v1);
    assign n_push = s1_go ? lmes_pkg::FCNT_W'(v0) + lmes_pkg::FCNT_W'(v1)
                          + lmes_pkg::FCNT_W'(v2) : '0;

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            if (v0) begin
                r_fifo[r_wp] <= d0;
            end
            if (v1) begin
                r_fifo[wp1] <= d1;
            end
            if (v2) begin
                r_fifo[wp2] <= d2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + n_push[lmes_pkg::FPTR_W-1:0];
            r_rp  <= r_rp + lmes_pkg::FPTR_W'(m_acc);
            r_cnt <= r_cnt + n_push - lmes_pkg::FCNT_W'(m_acc);
        end
    end

    assign o_m_tvalid = (r_cnt != '0);
    assign o_m_tdata  = {{lmes_pkg::PAD_W{1'b0}}, r_fifo[r_rp].lap,
                         r_fifo[r_rp].y, r_fifo[r_rp].x};
    assign o_m_tlast  = r_fifo[r_rp].eof;

endmodule

>>> rtl/core/lmes_checker.sv
// Port-level assertions for the Laplacian stream block, bound to its top level.
module lmes_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [lmes_pkg::ODATA_W-1:0]  o_m_tdata,
    input logic                          o_m_tlast
);

    logic signed [lmes_pkg::LAP_W-1:0] lap;
    assign lap = $signed(o_m_tdata[3*lmes_pkg::POS_W-1:2*lmes_pkg::POS_W]);

    // The result queue empties on reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // A stalled result item holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                       && $stable(o_m_tlast))
        else $error("stalled result changed");

    // Eight-bit pixels bound the Laplacian to plus or minus 1020.
    a_lap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (lap >= -11'sd1020) && (lap <= 11'sd1020))
        else $error("Laplacian out of range");

    // Padding above the packed fields stays zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[lmes_pkg::ODATA_W-1:3*lmes_pkg::POS_W] == '0)
        else $error("nonzero padding in result data");

endmodule

bind laplacian_mirror_edge_stream lmes_checker u_lmes_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

>>> sim/testbench.sv
// Self-checking testbench for the mirrored-border Laplacian stream block.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES   = 8;
    localparam int END_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SMALL_ITEMS    = 440;
    localparam int CALM_ITEMS     = 400;
    localparam int BIG_AFTER      = 200;
    localparam int BIG_ITEMS      = 24;

    typedef struct packed {
        logic                      is_cfg;
        logic                      idx;
        logic [lmes_pkg::CFG_W-1:0] value;
        logic                      typed;
        lmes_pkg::t_result         want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [lmes_pkg::PIX_W-1:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [lmes_pkg::ODATA_W-1:0] o_m_tdata;
    logic o_m_tlast;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_index = 1'b0;
    logic [lmes_pkg::CFG_W-1:0] i_cfg_data = '0;

    laplacian_mirror_edge_stream uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mirror of the block: two line stores, position and the last two pixels.
    logic [lmes_pkg::PIX_W-1:0] prev_line [lmes_pkg::MAX_WIDTH];
    logic [lmes_pkg::PIX_W-1:0] older_line [lmes_pkg::MAX_WIDTH];
    logic [lmes_pkg::CFG_W-1:0] width_reg;
    logic [lmes_pkg::CFG_W-1:0] height_reg;
    int                         col_pos;
    int                         row_pos;
    logic [lmes_pkg::PIX_W-1:0] left_pix;
    logic [lmes_pkg::PIX_W-1:0] left2_pix;

    lmes_pkg::t_result expected_laplacians [$];
    t_stim_row         directed_rows [$];
    bit                failed = 1'b0;
    bit                bursts_on = 1'b1;
    int                gap_pct = 20;
    int                stall_pct = 20;
    int                sink_stall = 0;
    int                quiet_cycles = 0;

    function automatic void restart_frame();
        col_pos   = 0;
        row_pos   = 0;
        left_pix  = '0;
        left2_pix = '0;
    endfunction

    function automatic int clamp_size(input logic [lmes_pkg::CFG_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > lmes_pkg::MAX_WIDTH) return lmes_pkg::MAX_WIDTH;
        return int'(v);
    endfunction

    function automatic void push_laplacian(input int x, input int y, input int l, input int r,
                                           input int u, input int d, input int c,
                                           input logic eof);
        lmes_pkg::t_result res;
        int                v;
        v = l + r + u + d - 4 * c;
        if (v > 1023) v = 1023;
        if (v < -1024) v = -1024;
        res.x   = lmes_pkg::POS_W'(x);
        res.y   = lmes_pkg::POS_W'(y);
        res.lap = lmes_pkg::LAP_W'(v);
        res.eof = eof;
        expected_laplacians.push_back(res);
    endfunction

    // Returns how many results the pixel causes; they are queued in output order.
    function automatic int predict_laplacians(input logic [lmes_pkg::PIX_W-1:0] pix);
        int w, h, x, y, n, ctr, right, lft, up, c, p;
        w = clamp_size(width_reg);
        h = clamp_size(height_reg);
        x = (col_pos >= w) ? w - 1 : col_pos;
        y = (row_pos >= h) ? h - 1 : row_pos;
        p = int'(pix);
        n = 0;
        ctr   = int'(prev_line[x]);
        right = (x + 1 < w) ? int'(prev_line[x + 1]) : ctr;
        if (y >= 1) begin
            lft = (x >= 1) ? int'(older_line[x - 1]) : ctr;
            up  = (y >= 2) ? int'(older_line[x]) : ctr;
            push_laplacian(x, y - 1, lft, right, up, p, ctr, 1'b0);
            n++;
        end
        older_line[x] = prev_line[x];
        prev_line[x]  = pix;
        // On the last row the row above is already in the older store.
        if (y == h - 1) begin
            if (x >= 1) begin
                c   = int'(left_pix);
                lft = (x >= 2) ? int'(left2_pix) : c;
                up  = (h >= 2) ? int'(older_line[x - 1]) : c;
                push_laplacian(x - 1, y, lft, p, up, c, c, 1'b0);
                n++;
            end
            if (x == w - 1) begin
                lft = (x >= 1) ? int'(left_pix) : p;
                up  = (h >= 2) ? int'(older_line[x]) : p;
                push_laplacian(x, y, lft, p, up, p, p, 1'b1);
                n++;
            end
        end
        left2_pix = left_pix;
        left_pix  = pix;
        if (x + 1 < w) begin
            col_pos = x + 1;
            row_pos = y;
        end else begin
            col_pos = 0;
            row_pos = (y + 1 < h) ? y + 1 : 0;
        end
        return n;
    endfunction

    function automatic t_stim_row cfg_row(input logic idx, input int val);
        t_stim_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.value  = lmes_pkg::CFG_W'(val);
        return r;
    endfunction

    function automatic t_stim_row pix_row(input int p);
        t_stim_row r;
        r       = '0;
        r.value = lmes_pkg::CFG_W'(p);
        return r;
    endfunction

    // A pixel whose first result is known by hand.
    function automatic t_stim_row known_row(input int p, input int x, input int y,
                                            input int lap, input logic eof);
        t_stim_row r;
        r          = pix_row(p);
        r.typed    = 1'b1;
        r.want.x   = lmes_pkg::POS_W'(x);
        r.want.y   = lmes_pkg::POS_W'(y);
        r.want.lap = lmes_pkg::LAP_W'(lap);
        r.want.eof = eof;
        return r;
    endfunction

    function automatic logic [lmes_pkg::PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return lmes_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [lmes_pkg::PIX_W-1:0] p, input logic typed,
                              input lmes_pkg::t_result want);
        int n;
        if (bursts_on && $urandom_range(0, 99) < gap_pct) begin
            repeat ($urandom_range(1, 7)) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= p;
        do @(posedge i_clk); while (!o_s_tready);
        n = predict_laplacians(p);
        if (typed && n > 0) begin
            expected_laplacians[expected_laplacians.size() - n] = want;
        end
    endtask

    task automatic write_reg(input logic idx, input logic [lmes_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_laplacians.size() != 0) @(posedge i_clk);
        // An item that gives no result may still be inside the block.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == lmes_pkg::REG_IMAGE_WIDTH) begin
            width_reg = val;
        end else begin
            height_reg = val;
        end
        restart_frame();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_frames(input int count);
        repeat (count) send_pixel(random_pixel(), 1'b0, '0);
    endtask

    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            i_m_tready <= 1'b0;
            sink_stall--;
        end else if (bursts_on && $urandom_range(0, 99) < stall_pct) begin
            i_m_tready <= 1'b0;
            sink_stall = $urandom_range(0, 6);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        lmes_pkg::t_result want;
        lmes_pkg::t_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.x   = o_m_tdata[lmes_pkg::POS_W-1:0];
            got.y   = o_m_tdata[2*lmes_pkg::POS_W-1:lmes_pkg::POS_W];
            got.lap = o_m_tdata[3*lmes_pkg::POS_W-1:2*lmes_pkg::POS_W];
            got.eof = o_m_tlast;
            if (expected_laplacians.size() == 0) begin
                $error("unexpected result: x_pos %0d y_pos %0d", got.x, got.y);
                failed = 1'b1;
            end else begin
                want = expected_laplacians.pop_front();
                if (got.x !== want.x) begin
                    $error("x_pos: expected %0d, actual %0d", want.x, got.x);
                    failed = 1'b1;
                end
                if (got.y !== want.y) begin
                    $error("y_pos: expected %0d, actual %0d", want.y, got.y);
                    failed = 1'b1;
                end
                if (got.lap !== want.lap) begin
                    $error("laplacian_value: expected %0d, actual %0d", want.lap, got.lap);
                    failed = 1'b1;
                end
                if (got.eof !== want.eof) begin
                    $error("end_of_frame: expected %0d, actual %0d", want.eof, got.eof);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int small_items;
        int w, h, frame, count;
        bit big_done;
        small_items = 0;
        big_done    = 1'b0;
        for (int i = 0; i < lmes_pkg::MAX_WIDTH; i++) begin
            prev_line[i]  = '0;
            older_line[i] = '0;
        end
        width_reg  = lmes_pkg::CFG_W'(lmes_pkg::MAX_WIDTH);
        height_reg = lmes_pkg::CFG_W'(2048);
        restart_frame();

        // Reset size: the first row of a full-size frame gives nothing yet.
        directed_rows.push_back(pix_row(0));
        directed_rows.push_back(pix_row(255));
        directed_rows.push_back(pix_row(8'h5A));
        // Zero sizes act as a single-pixel frame, whose Laplacian is always zero.
        directed_rows.push_back(cfg_row(lmes_pkg::REG_IMAGE_WIDTH, 0));
        directed_rows.push_back(cfg_row(lmes_pkg::REG_IMAGE_HEIGHT, 0));
        directed_rows.push_back(known_row(255, 0, 0, 0, 1'b1));
        directed_rows.push_back(known_row(0, 0, 0, 0, 1'b1));
        directed_rows.push_back(known_row(8'hA5, 0, 0, 0, 1'b1));
        // 3x3 frames: a bright dot on black, then a dark dot on white.
        directed_rows.push_back(cfg_row(lmes_pkg::REG_IMAGE_WIDTH, 3));
        directed_rows.push_back(cfg_row(lmes_pkg::REG_IMAGE_HEIGHT, 3));
        for (int i = 0; i < 4; i++) directed_rows.push_back(pix_row(0));
        directed_rows.push_back(pix_row(255));
        directed_rows.push_back(pix_row(0));
        directed_rows.push_back(pix_row(0));
        directed_rows.push_back(known_row(0, 1, 1, -1020, 1'b0));
        directed_rows.push_back(pix_row(0));
        for (int i = 0; i < 4; i++) directed_rows.push_back(pix_row(255));
        directed_rows.push_back(pix_row(0));
        directed_rows.push_back(pix_row(255));
        directed_rows.push_back(pix_row(255));
        directed_rows.push_back(known_row(255, 1, 1, 1020, 1'b0));
        directed_rows.push_back(pix_row(255));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            end else begin
                send_pixel(directed_rows[i].value[lmes_pkg::PIX_W-1:0],
                           directed_rows[i].typed, directed_rows[i].want);
            end
        end

        while (small_items < SMALL_ITEMS) begin
            if (small_items >= CALM_ITEMS) bursts_on = 1'b0;
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            case ($urandom_range(0, 9))
                0:       w = 0;
                7, 8:    w = $urandom_range(7, 24);
                9:       w = $urandom_range(25, 64);
                default: w = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 9))
                0:       h = 0;
                9:       h = $urandom_range(6, 10);
                default: h = $urandom_range(1, 5);
            endcase
            if (w > 24 && h > 3) h = $urandom_range(1, 3);
            // Half the time both registers; otherwise one alone still restarts the frame.
            case ($urandom_range(0, 3))
                0:       write_reg(lmes_pkg::REG_IMAGE_WIDTH, lmes_pkg::CFG_W'(w));
                1:       write_reg(lmes_pkg::REG_IMAGE_HEIGHT, lmes_pkg::CFG_W'(h));
                default: begin
                    write_reg(lmes_pkg::REG_IMAGE_WIDTH, lmes_pkg::CFG_W'(w));
                    write_reg(lmes_pkg::REG_IMAGE_HEIGHT, lmes_pkg::CFG_W'(h));
                end
            endcase
            frame = clamp_size(width_reg) * clamp_size(height_reg);
            // A cut-off frame is left behind by the next register write.
            if ($urandom_range(0, 4) == 0) begin
                count = $urandom_range(1, frame);
            end else begin
                count = frame * $urandom_range(1, 2);
            end
            if (count > SMALL_ITEMS - small_items) count = SMALL_ITEMS - small_items;
            send_frames(count);
            small_items += count;

            if (small_items >= BIG_AFTER && !big_done) begin
                big_done = 1'b1;
                // Oversize width on a single row must not wrap the row early.
                write_reg(lmes_pkg::REG_IMAGE_WIDTH,
                          lmes_pkg::CFG_W'($urandom_range(lmes_pkg::MAX_WIDTH + 1, 4095)));
                write_reg(lmes_pkg::REG_IMAGE_HEIGHT, lmes_pkg::CFG_W'(1));
                send_frames(BIG_ITEMS);
                // Oversize height on one column must not wrap the frame early.
                write_reg(lmes_pkg::REG_IMAGE_WIDTH, lmes_pkg::CFG_W'($urandom_range(0, 1)));
                write_reg(lmes_pkg::REG_IMAGE_HEIGHT,
                          lmes_pkg::CFG_W'($urandom_range(2049, 4095)));
                send_frames(BIG_ITEMS);
                small_items += 2 * BIG_ITEMS;
            end
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_laplacians.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (!failed) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
